// ----- src/base64_stream_decoder_core_assert.svh -----
// Assertion macros shared by the decoder RTL.
`ifndef BASE64_STREAM_DECODER_CORE_ASSERT_SVH
`define BASE64_STREAM_DECODER_CORE_ASSERT_SVH

// Check a condition at every clock edge outside reset.
`define B64_ASSERT_ALWAYS(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("base64 decoder check failed");

// Check that a condition implies another in the next cycle.
`define B64_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("base64 decoder check failed");

`endif

// ----- src/b64_pkg.sv -----
`default_nettype none
package b64_pkg;

   localparam logic [7:0] PAD_CHAR = 8'h3D;

   localparam logic [1:0] STATUS_OK          = 2'd0;
   localparam logic [1:0] STATUS_BAD_LENGTH  = 2'd1;
   localparam logic [1:0] STATUS_BAD_PADDING = 2'd2;

   typedef struct packed {
      logic [7:0] char_byte;
      logic       last_char;
   } req_type;

   typedef struct packed {
      logic [7:0] byte_a;
      logic [7:0] byte_b;
      logic [7:0] byte_c;
      logic [1:0] byte_count;
      logic       end_of_stream;
      logic [1:0] status;
   } rsp_type;

   typedef struct packed {
      logic       skip;
      logic       is_pad;
      logic [5:0] value;
   } sextet_type;

   // Map a character to its sextet; pad decodes as zero.
   function automatic sextet_type sextet_of(input logic [7:0] c);
      sextet_type d;
      d.skip   = 1'b0;
      d.is_pad = 1'b0;
      d.value  = 6'd0;
      if (c >= 8'h41 && c <= 8'h5A) begin
         d.value = 6'(c - 8'h41);
      end else if (c >= 8'h61 && c <= 8'h7A) begin
         d.value = 6'(c - 8'h61 + 8'd26);
      end else if (c >= 8'h30 && c <= 8'h39) begin
         d.value = 6'(c - 8'h30 + 8'd52);
      end else if (c == 8'h2B) begin
         d.value = 6'd62;
      end else if (c == 8'h2F) begin
         d.value = 6'd63;
      end else if (c == PAD_CHAR) begin
         d.is_pad = 1'b1;
      end else begin
         d.skip = 1'b1;
      end
      return d;
   endfunction

endpackage
`default_nettype wire

// ----- src/b64_group.sv -----
`default_nettype none
`include "base64_stream_decoder_core_assert.svh"
module b64_group
   import b64_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    step,
   input  wire req_type req,
   output rsp_type      rsp,
   output logic         emit
);

   logic [1:0] group_pos_ff, group_pos_in;
   logic [5:0] s0_ff, s0_in, s1_ff, s1_in, s2_ff, s2_in;
   logic [2:0] pad_seen_ff, pad_seen_in;
   logic       finished_ff, finished_in;
   logic [1:0] vmf_ff, vmf_in;
   logic       any_valid_ff, any_valid_in;
   logic       fault_ff, fault_in;

   sextet_type dec;
   logic       is_valid;
   logic       active;
   logic       complete;
   logic [2:0] pad_next;
   logic       group_fault;
   logic [1:0] cnt;

   always_comb begin
      dec      = sextet_of(req.char_byte);
      is_valid = !dec.skip;
      active   = is_valid && !finished_ff;
      pad_next = (dec.is_pad && pad_seen_ff != 3'd7) ? pad_seen_ff + 3'd1 : pad_seen_ff;
      complete    = active && (group_pos_ff == 2'd3);
      group_fault = (pad_next >= 3'd3);
      cnt         = group_fault ? 2'd0 : 2'(3'd3 - pad_next);

      group_pos_in = group_pos_ff;
      s0_in        = s0_ff;
      s1_in        = s1_ff;
      s2_in        = s2_ff;
      pad_seen_in  = pad_seen_ff;
      finished_in  = finished_ff;
      vmf_in       = is_valid ? vmf_ff + 2'd1 : vmf_ff;
      any_valid_in = any_valid_ff | is_valid;
      fault_in     = fault_ff;

      if (active) begin
         if (complete) begin
            group_pos_in = 2'd0;
            pad_seen_in  = 3'd0;
            if (group_fault) fault_in = 1'b1;
            if (pad_next != 3'd0) finished_in = 1'b1;
         end else begin
            pad_seen_in  = pad_next;
            group_pos_in = group_pos_ff + 2'd1;
            case (group_pos_ff)
               2'd0: s0_in = dec.value;
               2'd1: s1_in = dec.value;
               2'd2: s2_in = dec.value;
               default: s2_in = s2_ff;
            endcase
         end
      end

      rsp = '0;
      if (complete && !group_fault) begin
         rsp.byte_count = cnt;
         rsp.byte_a     = {s0_ff, s1_ff[5:4]};
         if (cnt >= 2'd2) rsp.byte_b = {s1_ff[3:0], s2_ff[5:2]};
         if (cnt == 2'd3) rsp.byte_c = {s2_ff[1:0], dec.value};
      end
      if (req.last_char) begin
         rsp.end_of_stream = 1'b1;
         if (!any_valid_in || vmf_in != 2'd0) begin
            rsp.status = STATUS_BAD_LENGTH;
         end else if (fault_in) begin
            rsp.status = STATUS_BAD_PADDING;
         end else begin
            rsp.status = STATUS_OK;
         end
      end
      emit = (complete && !group_fault) || req.last_char;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         group_pos_ff <= 2'd0;
         s0_ff        <= 6'd0;
         s1_ff        <= 6'd0;
         s2_ff        <= 6'd0;
         pad_seen_ff  <= 3'd0;
         finished_ff  <= 1'b0;
         vmf_ff       <= 2'd0;
         any_valid_ff <= 1'b0;
         fault_ff     <= 1'b0;
      end else if (step) begin
         if (req.last_char) begin
            // end of text: start clean for the next one
            group_pos_ff <= 2'd0;
            s0_ff        <= 6'd0;
            s1_ff        <= 6'd0;
            s2_ff        <= 6'd0;
            pad_seen_ff  <= 3'd0;
            finished_ff  <= 1'b0;
            vmf_ff       <= 2'd0;
            any_valid_ff <= 1'b0;
            fault_ff     <= 1'b0;
         end else begin
            group_pos_ff <= group_pos_in;
            s0_ff        <= s0_in;
            s1_ff        <= s1_in;
            s2_ff        <= s2_in;
            pad_seen_ff  <= pad_seen_in;
            finished_ff  <= finished_in;
            vmf_ff       <= vmf_in;
            any_valid_ff <= any_valid_in;
            fault_ff     <= fault_in;
         end
      end
   end

   `B64_ASSERT_NEXT(a_last_clears, clock, reset, step && req.last_char,
                    group_pos_ff == 2'd0 && !any_valid_ff && !fault_ff)
   `B64_ASSERT_ALWAYS(a_finished_idle, clock, reset,
                      !finished_ff || (group_pos_ff == 2'd0 && pad_seen_ff == 3'd0))

endmodule
`default_nettype wire

// ----- src/base64_stream_decoder_core.sv -----
// Streaming base64 decoder: one character per req beat, up to one rsp beat
// per character. A beat is held in the input register, where the group
// state is updated and the result formed, then waits in the result register;
// the sustained rate is one character per cycle, limited only by rsp_ready.
// A result appears when a four-sextet group completes with bytes, and on the
// beat marked last_char, which carries the end status (and any bytes of the
// group it closes). State returns to reset after the last character.
`default_nettype none
`include "base64_stream_decoder_core_assert.svh"
module base64_stream_decoder_core
   import b64_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   logic    in_valid_ff;
   req_type in_data_ff;
   logic    out_valid_ff;
   rsp_type out_data_ff;

   logic    advance;
   logic    step;
   logic    emit;
   rsp_type group_rsp;

   assign advance   = !out_valid_ff || rsp_ready;
   assign step      = in_valid_ff && advance;
   assign req_ready = !in_valid_ff || advance;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   b64_group u_group (
      .clock (clock),
      .reset (reset),
      .step  (step),
      .req   (in_data_ff),
      .rsp   (group_rsp),
      .emit  (emit)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_ready) in_valid_ff <= req_valid;
         // refill the result slot whenever it frees up
         if (advance) out_valid_ff <= step && emit;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) in_data_ff <= req_data;
      if (step && emit) out_data_ff <= group_rsp;
   end

   `B64_ASSERT_ALWAYS(a_rsp_not_empty, clock, reset,
                      !out_valid_ff || out_data_ff.byte_count != 2'd0
                      || out_data_ff.end_of_stream)
   `B64_ASSERT_ALWAYS(a_status_only_at_end, clock, reset,
                      !out_valid_ff || out_data_ff.end_of_stream
                      || out_data_ff.status == STATUS_OK)
   `B64_ASSERT_ALWAYS(a_unused_byte_zero, clock, reset,
                      !out_valid_ff || out_data_ff.byte_count == 2'd3
                      || out_data_ff.byte_c == 8'd0)

endmodule
`default_nettype wire

// ----- tb/tb_base64_stream_decoder_core.sv -----
`timescale 1ns / 1ps
module tb_base64_stream_decoder_core;
   import b64_pkg::*;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   base64_stream_decoder_core DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // decoder state mirrored in the testbench
   logic [1:0] grp_pos = '0;
   logic [5:0] held [3] = '{default: '0};
   logic [2:0] pad_cnt = '0;
   logic       text_done = 1'b0;
   logic [1:0] cnt_mod4 = '0;
   logic       any_char = 1'b0;
   logic       pad_err = 1'b0;

   rsp_type decoded_beats [$];

   int  errors = 0;
   int  chars_sent = 0;
   int  texts_sent = 0;
   int  beats_checked = 0;
   bit  idle_on = 1'b1;
   int  hold_cycles = 0;

   // -1 for characters outside the alphabet; pad maps to zero
   function automatic int sextet_index(input logic [7:0] c);
      if (c >= 8'h41 && c <= 8'h5A) return int'(c) - 8'h41;
      if (c >= 8'h61 && c <= 8'h7A) return int'(c) - 8'h61 + 26;
      if (c >= 8'h30 && c <= 8'h39) return int'(c) - 8'h30 + 52;
      if (c == 8'h2B) return 62;
      if (c == 8'h2F) return 63;
      if (c == PAD_CHAR) return 0;
      return -1;
   endfunction

   function automatic logic [7:0] alpha_char(input int idx);
      if (idx < 26) return 8'(8'h41 + idx);
      if (idx < 52) return 8'(8'h61 + idx - 26);
      if (idx < 62) return 8'(8'h30 + idx - 52);
      if (idx == 62) return 8'h2B;
      return 8'h2F;
   endfunction

   function automatic logic [7:0] noise_char();
      logic [7:0] c;
      c = 8'($urandom_range(255));
      while (sextet_index(c) >= 0) c = 8'($urandom_range(255));
      return c;
   endfunction

   task automatic clear_decoder();
      grp_pos   = '0;
      held      = '{default: '0};
      pad_cnt   = '0;
      text_done = 1'b0;
      cnt_mod4  = '0;
      any_char  = 1'b0;
      pad_err   = 1'b0;
   endtask

   task automatic decode_char(input logic [7:0] c, input logic last);
      int      v;
      rsp_type r;
      logic    emit;
      v    = sextet_index(c);
      r    = '0;
      emit = 1'b0;
      if (v >= 0) begin
         cnt_mod4 = cnt_mod4 + 2'd1;
         any_char = 1'b1;
         if (!text_done) begin
            if (c == PAD_CHAR && pad_cnt < 3'd7) pad_cnt = pad_cnt + 3'd1;
            if (grp_pos < 2'd3) begin
               held[grp_pos] = v[5:0];
               grp_pos = grp_pos + 2'd1;
            end else begin
               grp_pos = '0;
               if (pad_cnt >= 3'd3) begin
                  pad_err = 1'b1;
               end else begin
                  r.byte_a     = {held[0], held[1][5:4]};
                  r.byte_b     = {held[1][3:0], held[2][5:2]};
                  r.byte_c     = {held[2][1:0], v[5:0]};
                  r.byte_count = 2'(3'd3 - pad_cnt);
                  if (r.byte_count < 2'd3) r.byte_c = '0;
                  if (r.byte_count < 2'd2) r.byte_b = '0;
                  emit = 1'b1;
               end
               if (pad_cnt != 3'd0) text_done = 1'b1;
               pad_cnt = '0;
            end
         end
      end
      if (last) begin
         if (!any_char || cnt_mod4 != 2'd0) r.status = STATUS_BAD_LENGTH;
         else if (pad_err) r.status = STATUS_BAD_PADDING;
         else r.status = STATUS_OK;
         r.end_of_stream = 1'b1;
         emit = 1'b1;
         clear_decoder();
      end
      if (emit) decoded_beats.push_back(r);
   endtask

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
      errors++;
   endtask

   // one character per beat; valid stays up until the handshake completes
   task automatic send_char(input logic [7:0] c, input logic last);
      while (idle_on && $urandom_range(99) < 32) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{char_byte: c, last_char: last};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      decode_char(c, last);
      chars_sent++;
   endtask

   task automatic send_text(input logic [7:0] text [$]);
      foreach (text[i]) send_char(text[i], i == text.size() - 1);
      texts_sent++;
   endtask

   task automatic send_string(input string s, input bit close_text);
      for (int i = 0; i < s.len(); i++)
         send_char(s[i], close_text && i == s.len() - 1);
      if (close_text) texts_sent++;
   endtask

   // drop valid after the last accepted beat, then wait for the results
   task automatic wait_drain();
      req_valid <= 1'b0;
      while (decoded_beats.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // result side
   initial begin
      forever begin
         @(posedge clock);
         if (hold_cycles > 0) begin
            rsp_ready <= 1'b0;
            hold_cycles--;
         end else begin
            rsp_ready <= !(idle_on && $urandom_range(99) < 32);
         end
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (decoded_beats.size() == 0) begin
            report_mismatch("unexpected beat", int'(rsp_data), 0);
         end else begin
            want = decoded_beats.pop_front();
            beats_checked++;
            if (rsp_data.byte_a !== want.byte_a)
               report_mismatch("byte_a", int'(rsp_data.byte_a), int'(want.byte_a));
            if (rsp_data.byte_b !== want.byte_b)
               report_mismatch("byte_b", int'(rsp_data.byte_b), int'(want.byte_b));
            if (rsp_data.byte_c !== want.byte_c)
               report_mismatch("byte_c", int'(rsp_data.byte_c), int'(want.byte_c));
            if (rsp_data.byte_count !== want.byte_count)
               report_mismatch("byte_count", int'(rsp_data.byte_count),
                               int'(want.byte_count));
            if (rsp_data.end_of_stream !== want.end_of_stream)
               report_mismatch("end_of_stream", int'(rsp_data.end_of_stream),
                               int'(want.end_of_stream));
            if (rsp_data.status !== want.status)
               report_mismatch("status", int'(rsp_data.status), int'(want.status));
         end
      end
   end

   task automatic test_full_and_short_groups();
      send_char(8'h00, 1'b0);
      send_string("TWFu", 1'b0);
      send_char(8'hFF, 1'b0);
      send_string("//8=", 1'b1);
   endtask

   task automatic test_padding_fault();
      // three pads fault the group; later characters are only counted
      send_string("===A+/9z", 1'b1);
   endtask

   task automatic test_pad_inside_group();
      send_string("A=B=", 1'b1);
   endtask

   task automatic test_bad_length();
      send_string("AB", 1'b1);
      send_char(8'h80, 1'b1);
      texts_sent++;
   endtask

   task automatic test_random_texts(input int target, input bit idling);
      int         valid_chars;
      int         kind;
      int         groups;
      int         pads;
      int         len;
      int         pad_odds;
      logic [7:0] c;
      logic [7:0] text [$];
      idle_on = idling;
      valid_chars = 0;
      while (valid_chars < target) begin
         text.delete();
         kind = $urandom_range(9);
         if (kind < 8) begin
            groups = ($urandom_range(9) == 0) ? $urandom_range(1, 12) : $urandom_range(1, 3);
            pads = $urandom_range(2);
            for (int g = 0; g < groups; g++) begin
               for (int k = 0; k < 4; k++) begin
                  if ($urandom_range(9) == 0) text.push_back(noise_char());
                  if (g == groups - 1 && k >= 4 - pads) text.push_back(PAD_CHAR);
                  else text.push_back(alpha_char($urandom_range(63)));
               end
            end
            if ($urandom_range(7) == 0) text.push_back(noise_char());
         end else begin
            // broken text: stray pads, odd lengths, any byte value
            pad_odds = (kind == 9) ? 4 : 2;
            len = $urandom_range(14);
            for (int k = 0; k < len; k++) begin
               kind = $urandom_range(9);
               if (kind < pad_odds) text.push_back(PAD_CHAR);
               else if (kind < pad_odds + 2) text.push_back(8'($urandom_range(255)));
               else text.push_back(alpha_char($urandom_range(63)));
            end
            if (text.size() == 0) text.push_back(noise_char());
         end
         foreach (text[i]) begin
            c = text[i];
            if (sextet_index(c) >= 0) valid_chars++;
         end
         send_text(text);
      end
      wait_drain();
   endtask

   task automatic test_output_stall();
      logic [7:0] text [$];
      idle_on = 1'b0;
      hold_cycles = 150;
      for (int k = 0; k < 64; k++) text.push_back(alpha_char($urandom_range(63)));
      send_text(text);
      wait_drain();
      idle_on = 1'b1;
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_full_and_short_groups();
      test_padding_fault();
      test_pad_inside_group();
      test_bad_length();
      wait_drain();
      test_random_texts(750, 1'b1);
      test_output_stall();
      test_random_texts(250, 1'b0);
      test_random_texts(500, 1'b1);
      wait_drain();
      repeat (10) @(posedge clock);
      if (decoded_beats.size() != 0)
         report_mismatch("beats never delivered", 0, decoded_beats.size());
      $display("Sent %0d characters in %0d texts; checked %0d result beats.",
               chars_sent, texts_sent, beats_checked);
      $display("Texts mixed full groups, padded tails, faults, noise and output stalls.");
      if (errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("Timed out with %0d beats outstanding", decoded_beats.size());
      $display("FAILURE");
      $finish;
   end

endmodule

// ----- base64_stream_decoder_core.f -----
+incdir+src
src/b64_pkg.sv
src/b64_group.sv
src/base64_stream_decoder_core.sv
tb/tb_base64_stream_decoder_core.sv
